### hdl/mtpn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtpn_pkg
// Shared constants, types and helpers of the transport stream PID nuller.
// ----------------------------------------------------------------------------
package mtpn_pkg;

    localparam int TS_PACKET_BYTES = 188;
    localparam int MAX_TS_PACKETS  = 8;

    localparam int TS_START  = 42;
    localparam int PROTO_POS = 23;

    localparam logic [7:0]  PROTO_UDP    = 8'h11;
    localparam logic [7:0]  TS_SYNC_MARK = 8'h47;
    localparam logic [7:0]  NULL_PID_HI  = 8'h1F;
    localparam logic [7:0]  NULL_PID_LO  = 8'hFF;
    localparam logic [7:0]  NULL_CTRL    = 8'h10;
    localparam logic [7:0]  FILL_BYTE    = 8'hFF;
    localparam logic [12:0] PID_RESET    = 13'h101;

    localparam logic [7:0] OFF_SYNC   = 8'd0;
    localparam logic [7:0] OFF_PID_HI = 8'd1;
    localparam logic [7:0] OFF_PID_LO = 8'd2;
    localparam logic [7:0] OFF_CTRL   = 8'd3;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Results caused by one request: an optional leading byte, then the main byte.
    typedef struct packed {
        logic       pair;
        logic [7:0] first_byte;
        logic       first_eof;
        logic [7:0] main_byte;
        logic       main_eof;
    } qent_t;

    typedef struct packed {
        logic  valid;
        qent_t ent;
    } qpush_t;

    typedef struct packed {
        logic            full;
        logic            empty;
        logic [Q_CW-1:0] count;
    } qstat_t;

    // First frame position past transport packet idx.
    function automatic logic [16:0] pkt_end(input logic [3:0] idx);
        return 17'(TS_START + (int'(idx) + 1) * TS_PACKET_BYTES);
    endfunction

endpackage
`default_nettype wire

### hdl/mpegts_pid_nuller_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpegts_pid_nuller_top
// Passes Ethernet frame bytes, rewriting matching-PID transport packets
// inside UDP frames as null packets.
//
//   port group    dir   handshake               payload
//   in            in    in_valid / in_ready     data_byte, start_of_frame,
//                                               frame_length
//   out           out   out_valid / out_ready   out_byte, end_of_frame,
//                                               last_of_step
//   cfg           in    cfg_valid / cfg_ready   target_pid
//
// One request per clock while in_ready is high; its results leave one per
// clock while out_ready is high, the first passing through the queue entry
// (written at the accepting edge) and then the output register.
// Two results from one request leave one after the other; the four-entry
// queue absorbs them.
// in_ready drops only while the queue is full; cfg_ready is always high.
// Reset clears all position and packet state and loads PID 0x101.
// ----------------------------------------------------------------------------
module mpegts_pid_nuller_top
    import mtpn_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        start_of_frame,
    input  wire logic [15:0] frame_length,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic             end_of_frame,
    output logic             last_of_step,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [12:0] target_pid
);

    qpush_t q_push;
    qent_t  q_head;
    qstat_t q_stat;
    logic   q_pop;

    mtpn_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .start_of_frame (start_of_frame),
        .frame_length   (frame_length),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .target_pid     (target_pid),
        .q_full         (q_stat.full),
        .push           (q_push)
    );

    mtpn_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .pop   (q_pop),
        .head  (q_head),
        .stat  (q_stat)
    );

    mtpn_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_head),
        .stat         (q_stat),
        .pop          (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .end_of_frame (end_of_frame),
        .last_of_step (last_of_step)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push.valid && q_stat.full))
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.count <= Q_CW'(Q_DEPTH))
        else $error("queue count out of range");

    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_of_step) |=> out_valid)
        else $error("second result of a request missing");

endmodule
`default_nettype wire

### hdl/mtpn_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtpn_front
// Frame parser: tracks position, UDP and packet state, decides rewrites.
// ----------------------------------------------------------------------------
module mtpn_front
    import mtpn_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        start_of_frame,
    input  wire logic [15:0] frame_length,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [12:0] target_pid,
    input  wire logic        q_full,
    output qpush_t           push
);

    logic [12:0] pid_reg;
    logic [15:0] pos_reg, pos_next, pos_e;
    logic [15:0] len_reg, len_next, len_e;
    logic        udp_reg, udp_next, udp_e;
    logic [3:0]  idx_reg, idx_next, idx_e;
    logic [7:0]  off_reg, off_next, off_e;
    logic        sync_reg, sync_next, sync_e;
    logic [7:0]  held_reg, held_next, held_e;
    logic        blank_reg, blank_next, blank_e;

    logic        acc;
    logic        flush;
    logic        hold;
    logic        pre;
    logic [7:0]  pre_byte;
    logic [7:0]  outb;
    logic        eof;
    logic        blank_now;
    logic [8:0]  off_inc;

    function automatic logic examined(input logic udp, input logic [3:0] idx,
                                      input logic [15:0] len);
        return udp && (5'(idx) < 5'(MAX_TS_PACKETS)) && (pkt_end(idx) <= {1'b0, len});
    endfunction

    assign in_ready  = !q_full;
    assign cfg_ready = 1'b1;
    assign acc       = in_valid && in_ready;

    always_comb
    begin
        flush = start_of_frame && (pos_reg > 16'(TS_START)) && (off_reg == OFF_PID_LO)
                && examined(udp_reg, idx_reg, len_reg);

        pos_e   = start_of_frame ? 16'd0 : pos_reg;
        len_e   = start_of_frame ? frame_length : len_reg;
        udp_e   = start_of_frame ? 1'b0 : udp_reg;
        idx_e   = start_of_frame ? 4'd0 : idx_reg;
        off_e   = start_of_frame ? 8'd0 : off_reg;
        sync_e  = start_of_frame ? 1'b0 : sync_reg;
        held_e  = start_of_frame ? 8'd0 : held_reg;
        blank_e = start_of_frame ? 1'b0 : blank_reg;

        udp_next   = udp_e;
        idx_next   = idx_e;
        off_next   = off_e;
        sync_next  = sync_e;
        held_next  = held_e;
        blank_next = blank_e;
        len_next   = len_e;
        pos_next   = (pos_e != 16'hFFFF) ? pos_e + 16'd1 : pos_e;

        eof       = ({1'b0, pos_e} + 17'd1) == {1'b0, len_e};
        outb      = data_byte;
        hold      = 1'b0;
        pre       = 1'b0;
        pre_byte  = held_e;
        blank_now = blank_e;
        off_inc   = {1'b0, off_e} + 9'd1;

        if (pos_e == 16'(PROTO_POS))
        begin
            udp_next = (data_byte == PROTO_UDP);
        end

        if (pos_e >= 16'(TS_START))
        begin
            if (examined(udp_e, idx_e, len_e))
            begin
                case (off_e)
                    OFF_SYNC:
                    begin
                        sync_next = (data_byte == TS_SYNC_MARK);
                    end
                    OFF_PID_HI:
                    begin
                        held_next = data_byte;
                        hold      = 1'b1;
                    end
                    OFF_PID_LO:
                    begin
                        blank_now  = blank_e
                                     || (sync_e && ({held_e[4:0], data_byte} == pid_reg));
                        blank_next = blank_now;
                        pre        = 1'b1;
                        pre_byte   = blank_now ? NULL_PID_HI : held_e;
                        outb       = blank_now ? NULL_PID_LO : data_byte;
                    end
                    OFF_CTRL:
                    begin
                        outb = blank_e ? NULL_CTRL : data_byte;
                    end
                    default:
                    begin
                        outb = blank_e ? FILL_BYTE : data_byte;
                    end
                endcase
            end
            if (off_inc >= 9'(TS_PACKET_BYTES))
            begin
                off_next   = 8'd0;
                blank_next = 1'b0;
                sync_next  = 1'b0;
                if (idx_e != 4'd15)
                begin
                    idx_next = idx_e + 4'd1;
                end
            end
            else
            begin
                off_next = off_inc[7:0];
            end
        end

        push.valid          = acc && !hold;
        push.ent.pair       = flush || pre;
        push.ent.first_byte = flush ? held_reg : pre_byte;
        push.ent.first_eof  = flush;
        push.ent.main_byte  = outb;
        push.ent.main_eof   = eof;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pid_reg <= PID_RESET;
        end
        else if (cfg_valid)
        begin
            pid_reg <= target_pid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            len_reg   <= '0;
            udp_reg   <= 1'b0;
            idx_reg   <= '0;
            off_reg   <= '0;
            sync_reg  <= 1'b0;
            held_reg  <= '0;
            blank_reg <= 1'b0;
        end
        else if (acc)
        begin
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            udp_reg   <= udp_next;
            idx_reg   <= idx_next;
            off_reg   <= off_next;
            sync_reg  <= sync_next;
            held_reg  <= held_next;
            blank_reg <= blank_next;
        end
    end

endmodule
`default_nettype wire

### hdl/mtpn_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtpn_queue
// Short first-in first-out queue of result groups between front and back.
// ----------------------------------------------------------------------------
module mtpn_queue
    import mtpn_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire qpush_t push,
    input  wire logic   pop,
    output qent_t       head,
    output qstat_t      stat
);

    qent_t           mem_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CW-1:0] count_reg, count_next;
    logic            do_pop;

    assign do_pop     = pop && (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == Q_CW'(Q_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign stat.count = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push.valid && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push.valid && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem_reg[wr_ptr_reg] <= push.ent;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

### hdl/mtpn_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtpn_back
// Result serializer: splits queued groups into single output bytes.
// ----------------------------------------------------------------------------
module mtpn_back
    import mtpn_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire qent_t  head,
    input  wire qstat_t stat,
    output logic        pop,
    output logic        out_valid,
    input  wire logic   out_ready,
    output logic [7:0]  out_byte,
    output logic        end_of_frame,
    output logic        last_of_step
);

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       eof_reg;
    logic       last_reg;
    logic       sec_valid_reg;
    logic [7:0] sec_byte_reg;
    logic       sec_eof_reg;
    logic       load_ok;

    assign load_ok      = !valid_reg || out_ready;
    assign pop          = load_ok && !sec_valid_reg && !stat.empty;
    assign out_valid    = valid_reg;
    assign out_byte     = byte_reg;
    assign end_of_frame = eof_reg;
    assign last_of_step = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            sec_valid_reg <= 1'b0;
        end
        else if (load_ok)
        begin
            if (sec_valid_reg)
            begin
                valid_reg     <= 1'b1;
                sec_valid_reg <= 1'b0;
            end
            else
            begin
                valid_reg     <= !stat.empty;
                sec_valid_reg <= !stat.empty && head.pair;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ok)
        begin
            if (sec_valid_reg)
            begin
                byte_reg <= sec_byte_reg;
                eof_reg  <= sec_eof_reg;
                last_reg <= 1'b1;
            end
            else if (head.pair)
            begin
                byte_reg     <= head.first_byte;
                eof_reg      <= head.first_eof;
                last_reg     <= 1'b0;
                sec_byte_reg <= head.main_byte;
                sec_eof_reg  <= head.main_eof;
            end
            else
            begin
                byte_reg <= head.main_byte;
                eof_reg  <= head.main_eof;
                last_reg <= 1'b1;
            end
        end
    end

endmodule
`default_nettype wire
